FILE: rtl/core/dsrm_pkg.sv
// Package for the double sphere rectify map unit.
// Register indexes, datapath widths and the sideband structs of the pipeline.
// No dependencies.
package dsrm_pkg;

  localparam int unsigned MAX_COLS = 4096;
  localparam int unsigned MAX_ROWS = 4096;
  localparam int unsigned NUM_REGS = 7;

  typedef enum logic [2:0] {
    REG_COEF_01,
    REG_COEF_23,
    REG_COEF_45,
    REG_COEF_67,
    REG_COEF_8AX,
    REG_FOCAL,
    REG_CENTER
  } reg_idx_e;

  localparam int unsigned RAD_W     = 64;
  localparam int unsigned ROOT_W    = 32;
  localparam int unsigned SQ_STAGES = 32;
  localparam int unsigned NUM_W     = 62;
  localparam int unsigned DEN_W     = 49;
  localparam int unsigned QUO_W     = 36;
  localparam int unsigned FRAC_SH   = 16;
  localparam int unsigned SAT_SH    = 20;
  localparam int unsigned REM_W     = 85;

  // front stages 7, two roots 32 each, t path 3, den path 2, divider 37, output 1
  localparam int unsigned PIPE_LATENCY = 114;

  typedef struct packed {
    logic signed [29:0] x;
    logic signed [29:0] y;
    logic signed [29:0] z;
    logic        [58:0] sq;
    logic signed [31:0] t;
    logic               in_range;
  } ray_side_t;

  typedef struct packed {
    logic        neg;
    logic [31:0] cen;
    logic        den_pos;
    logic        in_range;
  } div_side_t;

endpackage

FILE: rtl/core/dsrm_isqrt.sv
// Pipelined floor integer square root, one result bit per stage.
// Carries a ray_side_t sideband alongside; depends on dsrm_pkg.
module dsrm_isqrt import dsrm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [RAD_W-1:0]  rad_i,
  input  ray_side_t         side_i,
  output logic              valid_o,
  output logic [ROOT_W-1:0] root_o,
  output ray_side_t         side_o
);

  logic              vld_q  [SQ_STAGES];
  logic [RAD_W-1:0]  n_q    [SQ_STAGES];
  logic [RAD_W-1:0]  res_q  [SQ_STAGES];
  ray_side_t         side_q [SQ_STAGES];

  for (genvar i = 0; i < SQ_STAGES; i++) begin : g_stage
    localparam logic [RAD_W-1:0] Bit = RAD_W'(1) << (RAD_W - 2 - 2 * i);
    logic             vld;
    logic [RAD_W-1:0] n, res, trial;
    ray_side_t        sd;
    logic             ge;

    if (i == 0) begin : g_first
      assign vld = valid_i;
      assign n   = rad_i;
      assign res = '0;
      assign sd  = side_i;
    end else begin : g_next
      assign vld = vld_q[i-1];
      assign n   = n_q[i-1];
      assign res = res_q[i-1];
      assign sd  = side_q[i-1];
    end

    assign trial = res + Bit;
    assign ge    = n >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else begin
        vld_q[i] <= vld;
      end
    end

    always_ff @(posedge clk_i) begin
      n_q[i]    <= ge ? n - trial : n;
      res_q[i]  <= ge ? (res >> 1) + Bit : res >> 1;
      side_q[i] <= sd;
    end
  end

  assign valid_o = vld_q[SQ_STAGES-1];
  assign root_o  = res_q[SQ_STAGES-1][ROOT_W-1:0];
  assign side_o  = side_q[SQ_STAGES-1];

endmodule

FILE: rtl/core/dsrm_div.sv
// Pipelined restoring divider: floor(num * 2^16 / den), one quotient bit per stage,
// with an overflow flag when num / den reaches 2^20. Depends on dsrm_pkg.
module dsrm_div import dsrm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  input  div_side_t        side_i,
  output logic             valid_o,
  output logic [QUO_W-1:0] quo_o,
  output logic             sat_o,
  output div_side_t        side_o
);

  logic             vld_q  [QUO_W+1];
  logic [REM_W-1:0] rem_q  [QUO_W+1];
  logic [QUO_W-1:0] quo_q  [QUO_W+1];
  logic [DEN_W-1:0] den_q  [QUO_W+1];
  logic             sat_q  [QUO_W+1];
  div_side_t        side_q [QUO_W+1];

  logic [REM_W-1:0] sat_lim;
  assign sat_lim = REM_W'(den_i) << SAT_SH;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0]  <= REM_W'(num_i) << FRAC_SH;
    quo_q[0]  <= '0;
    den_q[0]  <= den_i;
    sat_q[0]  <= REM_W'(num_i) >= sat_lim;
    side_q[0] <= side_i;
  end

  for (genvar i = 0; i < QUO_W; i++) begin : g_stage
    localparam int unsigned K = QUO_W - 1 - i;
    logic [REM_W-1:0] dsh;
    logic             ge;

    assign dsh = REM_W'(den_q[i]) << K;
    assign ge  = rem_q[i] >= dsh;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else begin
        vld_q[i+1] <= vld_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[i+1]  <= ge ? rem_q[i] - dsh : rem_q[i];
      quo_q[i+1]  <= quo_q[i] | (QUO_W'(ge) << K);
      den_q[i+1]  <= den_q[i];
      sat_q[i+1]  <= sat_q[i];
      side_q[i+1] <= side_q[i];
    end
  end

  assign valid_o = vld_q[QUO_W];
  assign quo_o   = quo_q[QUO_W];
  assign sat_o   = sat_q[QUO_W];
  assign side_o  = side_q[QUO_W];

endmodule

FILE: rtl/core/double_sphere_rectify_map_unit.sv
// Double sphere rectify map: rectified pixel to source fisheye map coordinate.
// Top level; depends on dsrm_pkg, dsrm_isqrt and dsrm_div.
//
// One coordinate is taken on every clock: busy never rises, so start may be
// held high for a whole raster. Each result shows up on done_o for a single
// cycle; the receiver cannot stall, and the pipeline holds the two 32-stage
// square roots and the 37-stage dividers. The user must write registers
// through cfg_we_i only while no transfer is in flight; the block itself
// does not enforce this.
module double_sphere_rectify_map_unit import dsrm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [11:0]        pixel_col_i,
  input  logic [11:0]        pixel_row_i,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [63:0]        cfg_data_i,
  output logic               done_o,
  output logic signed [31:0] map_x_o,
  output logic signed [31:0] map_y_o,
  output logic               map_valid_o
);

  logic [63:0] cfg_q [NUM_REGS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) cfg_q[i] <= '0;
    end else if (cfg_we_i && (cfg_idx_i < 3'(NUM_REGS))) begin
      cfg_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  logic signed [31:0] m0, m1, m2, m3, m4, m5, m6, m7, m8;
  logic        [15:0] alpha;
  logic signed [15:0] xi;
  logic        [31:0] fx, fy, cx, cy;

  assign m0    = cfg_q[REG_COEF_01][31:0];
  assign m1    = cfg_q[REG_COEF_01][63:32];
  assign m2    = cfg_q[REG_COEF_23][31:0];
  assign m3    = cfg_q[REG_COEF_23][63:32];
  assign m4    = cfg_q[REG_COEF_45][31:0];
  assign m5    = cfg_q[REG_COEF_45][63:32];
  assign m6    = cfg_q[REG_COEF_67][31:0];
  assign m7    = cfg_q[REG_COEF_67][63:32];
  assign m8    = cfg_q[REG_COEF_8AX][31:0];
  assign alpha = cfg_q[REG_COEF_8AX][47:32];
  assign xi    = cfg_q[REG_COEF_8AX][63:48];
  assign fx    = cfg_q[REG_FOCAL][31:0];
  assign fy    = cfg_q[REG_FOCAL][63:32];
  assign cx    = cfg_q[REG_CENTER][31:0];
  assign cy    = cfg_q[REG_CENTER][63:32];

  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // stage 1: matrix products
  logic               v1_q;
  logic signed [44:0] p0_q, p1_q, p3_q, p4_q, p6_q, p7_q;
  logic               inr1_q;
  logic signed [12:0] col_s, row_s;

  assign col_s = $signed({1'b0, pixel_col_i});
  assign row_s = $signed({1'b0, pixel_row_i});

  always_ff @(posedge clk_i) begin
    p0_q   <= m0 * col_s;
    p1_q   <= m1 * row_s;
    p3_q   <= m3 * col_s;
    p4_q   <= m4 * row_s;
    p6_q   <= m6 * col_s;
    p7_q   <= m7 * row_s;
    inr1_q <= ({3'b0, pixel_col_i} < 15'(MAX_COLS)) && ({3'b0, pixel_row_i} < 15'(MAX_ROWS));
  end

  // stage 2: ray sums
  logic               v2_q, inr2_q;
  logic signed [46:0] x2_q, y2_q, z2_q;

  always_ff @(posedge clk_i) begin
    x2_q   <= 47'(p0_q) + 47'(p1_q) + 47'(m2);
    y2_q   <= 47'(p3_q) + 47'(p4_q) + 47'(m5);
    z2_q   <= 47'(p6_q) + 47'(p7_q) + 47'(m8);
    inr2_q <= inr1_q;
  end

  // stage 3: magnitude OR, same leading one as the max
  logic               v3_q, inr3_q;
  logic signed [46:0] x3_q, y3_q, z3_q;
  logic        [46:0] mag3_q;
  logic        [46:0] ax2, ay2, az2;

  assign ax2 = x2_q[46] ? 47'(-x2_q) : 47'(x2_q);
  assign ay2 = y2_q[46] ? 47'(-y2_q) : 47'(y2_q);
  assign az2 = z2_q[46] ? 47'(-z2_q) : 47'(z2_q);

  always_ff @(posedge clk_i) begin
    x3_q   <= x2_q;
    y3_q   <= y2_q;
    z3_q   <= z2_q;
    mag3_q <= ax2 | ay2 | az2;
    inr3_q <= inr2_q;
  end

  // stage 4: normalizing shift amount
  logic               v4_q, inr4_q, right4_q;
  logic        [4:0]  amt4_q;
  logic signed [46:0] x4_q, y4_q, z4_q;
  logic        [5:0]  pos3;

  always_comb begin
    pos3 = '0;
    for (int b = 0; b < 47; b++) begin
      if (mag3_q[b]) pos3 = 6'(b);
    end
  end

  always_ff @(posedge clk_i) begin
    x4_q     <= x3_q;
    y4_q     <= y3_q;
    z4_q     <= z3_q;
    right4_q <= pos3 > 6'd27;
    amt4_q   <= (pos3 > 6'd27) ? 5'(pos3 - 6'd27) : 5'(6'd27 - pos3);
    inr4_q   <= inr3_q;
  end

  // stage 5: block normalize to [2^27, 2^28)
  logic               v5_q, inr5_q;
  logic signed [29:0] x5_q, y5_q, z5_q;
  logic signed [46:0] xs4, ys4, zs4;

  assign xs4 = right4_q ? (x4_q >>> amt4_q) : (x4_q <<< amt4_q);
  assign ys4 = right4_q ? (y4_q >>> amt4_q) : (y4_q <<< amt4_q);
  assign zs4 = right4_q ? (z4_q >>> amt4_q) : (z4_q <<< amt4_q);

  always_ff @(posedge clk_i) begin
    x5_q   <= xs4[29:0];
    y5_q   <= ys4[29:0];
    z5_q   <= zs4[29:0];
    inr5_q <= inr4_q;
  end

  // stage 6: squares
  logic               v6_q, inr6_q;
  logic signed [29:0] x6_q, y6_q, z6_q;
  logic        [57:0] xx6_q, yy6_q, zz6_q;
  logic signed [59:0] xx5, yy5, zz5;

  assign xx5 = x5_q * x5_q;
  assign yy5 = y5_q * y5_q;
  assign zz5 = z5_q * z5_q;

  always_ff @(posedge clk_i) begin
    x6_q   <= x5_q;
    y6_q   <= y5_q;
    z6_q   <= z5_q;
    xx6_q  <= xx5[57:0];
    yy6_q  <= yy5[57:0];
    zz6_q  <= zz5[57:0];
    inr6_q <= inr5_q;
  end

  // stage 7: radicand of d1
  logic             v7_q;
  logic [RAD_W-1:0] rad7_q;
  ray_side_t        side7_q;
  logic [58:0]      sq6;

  assign sq6 = 59'(xx6_q) + 59'(yy6_q);

  always_ff @(posedge clk_i) begin
    rad7_q           <= RAD_W'(sq6) + RAD_W'(zz6_q);
    side7_q.x        <= x6_q;
    side7_q.y        <= y6_q;
    side7_q.z        <= z6_q;
    side7_q.sq       <= sq6;
    side7_q.t        <= '0;
    side7_q.in_range <= inr6_q;
  end

  logic              r1_vld;
  logic [ROOT_W-1:0] d1;
  ray_side_t         r1_side;

  dsrm_isqrt u_isqrt_d1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v7_q),
    .rad_i   (rad7_q),
    .side_i  (side7_q),
    .valid_o (r1_vld),
    .root_o  (d1),
    .side_o  (r1_side)
  );

  // stage 8: xi * d1
  logic               v8_q;
  logic signed [48:0] xt8_q;
  ray_side_t          side8_q;

  always_ff @(posedge clk_i) begin
    xt8_q   <= xi * $signed({1'b0, d1});
    side8_q <= r1_side;
  end

  // stage 9: t, rounded
  logic               v9_q;
  ray_side_t          side9_q, side9_d;
  logic signed [49:0] tsum8;

  assign tsum8 = 50'(xt8_q) + (50'(side8_q.z) <<< 14) + 50'sd8192;

  always_comb begin
    side9_d   = side8_q;
    side9_d.t = tsum8[45:14];
  end

  always_ff @(posedge clk_i) begin
    side9_q <= side9_d;
  end

  // stage 10: t squared
  logic               v10_q;
  logic [RAD_W-1:0]   tt10_q;
  ray_side_t          side10_q;
  logic signed [63:0] tt9;

  assign tt9 = side9_q.t * side9_q.t;

  always_ff @(posedge clk_i) begin
    tt10_q   <= tt9;
    side10_q <= side9_q;
  end

  logic              r2_vld;
  logic [ROOT_W-1:0] d2;
  ray_side_t         r2_side;

  dsrm_isqrt u_isqrt_d2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v10_q),
    .rad_i   (RAD_W'(side10_q.sq) + tt10_q),
    .side_i  (side10_q),
    .valid_o (r2_vld),
    .root_o  (d2),
    .side_o  (r2_side)
  );

  // stage 12: denominator terms, magnitudes of x and y
  logic               v12_q, inr12_q, negx12_q, negy12_q;
  logic        [47:0] pa12_q;
  logic signed [48:0] pb12_q;
  logic        [29:0] ax12_q, ay12_q;
  logic signed [16:0] beta;

  assign beta = 17'sd32768 - $signed({1'b0, alpha});

  always_ff @(posedge clk_i) begin
    pa12_q   <= alpha * d2;
    pb12_q   <= beta * r2_side.t;
    ax12_q   <= r2_side.x[29] ? 30'(-r2_side.x) : 30'(r2_side.x);
    ay12_q   <= r2_side.y[29] ? 30'(-r2_side.y) : 30'(r2_side.y);
    negx12_q <= r2_side.x[29];
    negy12_q <= r2_side.y[29];
    inr12_q  <= r2_side.in_range;
  end

  // stage 13: den and numerators
  logic               v13_q, inr13_q, negx13_q, negy13_q;
  logic signed [49:0] den13_q;
  logic [NUM_W-1:0]   nx13_q, ny13_q;
  logic               den_pos;
  div_side_t          dsx, dsy;

  always_ff @(posedge clk_i) begin
    den13_q  <= $signed({2'b0, pa12_q}) + 50'(pb12_q);
    nx13_q   <= fx * ax12_q;
    ny13_q   <= fy * ay12_q;
    negx13_q <= negx12_q;
    negy13_q <= negy12_q;
    inr13_q  <= inr12_q;
  end

  assign den_pos = !den13_q[49] && (den13_q != '0);

  assign dsx = '{neg: negx13_q, cen: cx, den_pos: den_pos, in_range: inr13_q};
  assign dsy = '{neg: negy13_q, cen: cy, den_pos: den_pos, in_range: inr13_q};

  logic             qx_vld, qy_vld, satx, saty;
  logic [QUO_W-1:0] qx, qy;
  div_side_t        qx_side, qy_side;

  dsrm_div u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v13_q),
    .num_i   (nx13_q),
    .den_i   (den13_q[DEN_W-1:0]),
    .side_i  (dsx),
    .valid_o (qx_vld),
    .quo_o   (qx),
    .sat_o   (satx),
    .side_o  (qx_side)
  );

  dsrm_div u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v13_q),
    .num_i   (ny13_q),
    .den_i   (den13_q[DEN_W-1:0]),
    .side_i  (dsy),
    .valid_o (qy_vld),
    .quo_o   (qy),
    .sat_o   (saty),
    .side_o  (qy_side)
  );

  // final: round, add center, saturate
  localparam logic signed [31:0] I32Max = 32'sh7fffffff;
  localparam logic signed [31:0] I32Min = 32'sh80000000;

  logic [QUO_W-1:0]   rx, ry;
  logic signed [37:0] vx, vy;
  logic signed [31:0] ox, oy;
  logic               ovx, ovy, ok;

  assign rx = QUO_W'((37'(qx) + 37'd1) >> 1);
  assign ry = QUO_W'((37'(qy) + 37'd1) >> 1);
  assign vx = qx_side.neg ? $signed({6'b0, qx_side.cen}) - $signed({2'b0, rx})
                          : $signed({6'b0, qx_side.cen}) + $signed({2'b0, rx});
  assign vy = qy_side.neg ? $signed({6'b0, qy_side.cen}) - $signed({2'b0, ry})
                          : $signed({6'b0, qy_side.cen}) + $signed({2'b0, ry});

  always_comb begin
    ovx = 1'b0;
    ovy = 1'b0;
    if (satx) begin
      ox  = qx_side.neg ? I32Min : I32Max;
      ovx = 1'b1;
    end else if (vx > 38'(I32Max)) begin
      ox  = I32Max;
      ovx = 1'b1;
    end else if (vx < 38'(I32Min)) begin
      ox  = I32Min;
      ovx = 1'b1;
    end else begin
      ox = vx[31:0];
    end
    if (saty) begin
      oy  = qy_side.neg ? I32Min : I32Max;
      ovy = 1'b1;
    end else if (vy > 38'(I32Max)) begin
      oy  = I32Max;
      ovy = 1'b1;
    end else if (vy < 38'(I32Min)) begin
      oy  = I32Min;
      ovy = 1'b1;
    end else begin
      oy = vy[31:0];
    end
    if (!qx_side.den_pos) begin
      ox = I32Min;
      oy = I32Min;
    end
    ok = qx_side.den_pos && !ovx && !ovy && qx_side.in_range;
  end

  always_ff @(posedge clk_i) begin
    map_x_o <= ox;
    map_y_o <= oy;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      v5_q        <= 1'b0;
      v6_q        <= 1'b0;
      v7_q        <= 1'b0;
      v8_q        <= 1'b0;
      v9_q        <= 1'b0;
      v10_q       <= 1'b0;
      v12_q       <= 1'b0;
      v13_q       <= 1'b0;
      done_o      <= 1'b0;
      map_valid_o <= 1'b0;
    end else begin
      v1_q        <= accept;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      v4_q        <= v3_q;
      v5_q        <= v4_q;
      v6_q        <= v5_q;
      v7_q        <= v6_q;
      v8_q        <= r1_vld;
      v9_q        <= v8_q;
      v10_q       <= v9_q;
      v12_q       <= r2_vld;
      v13_q       <= v12_q;
      done_o      <= qx_vld;
      map_valid_o <= qx_vld && ok;
    end
  end

  a_valid_has_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    map_valid_o |-> done_o)
    else $error("map_valid_o without done_o");

  a_done_from_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, PIPE_LATENCY))
    else $error("done_o without a start at pipeline latency");

  a_lanes_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qx_vld == qy_vld)
    else $error("divider lanes out of step");

endmodule
